// ----- rtl/tmb_pkg.sv -----
package tmb_pkg;

    // Operation codes carried by the mode field
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_START  = 3'd2,
        OP_STOP   = 3'd3,
        OP_TOGGLE = 3'd4,
        OP_QUERY  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    localparam int CHAN_W      = 3;
    localparam int ACT_W       = 4;
    localparam int ACT_MAX     = 15;
    localparam int MAX_RESULTS = 8;
    localparam int RES_IDX_W   = 3;
    localparam int RES_CNT_W   = 4;

    typedef struct packed {
        logic in_fire;
        logic is_tick;
        logic sweep_done;
        logic res_empty;
        logic out_free;
        logic emit_last;
    } fsm_status_t;

    typedef struct packed {
        logic in_ready;
        logic resp_load;
        logic sweep_run;
        logic emit_load;
    } fsm_ctrl_t;

endpackage

// ----- rtl/tmb_ram.sv -----
module tmb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tmb_fsm.sv -----
module tmb_fsm
    import tmb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fsm_status_t status,
    output fsm_ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_fire)
                begin
                    state_next = status.is_tick ? ST_SWEEP : ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (status.sweep_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.res_empty || (status.out_free && status.emit_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ST_RESP:
            begin
                ctrl.resp_load = status.out_free;
            end
            ST_SWEEP:
            begin
                ctrl.sweep_run = 1'b1;
            end
            ST_EMIT:
            begin
                ctrl.emit_load = status.out_free && !status.res_empty;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ----- rtl/multi_channel_software_timer_bank_unit.sv -----
// Channel | Handshake            | Beat contents
// --------+----------------------+-----------------------------------------------
// input   | in_valid / in_ready  | mode, timer_id, ticks, periodic
// output  | out_valid / out_ready| expiry_event, channel, expired, enabled, paused,
//         |                      | active_count, accepted, last
//
// Sequence: allocate, start, stop, toggle and query accept, then load the output
// register; a tick sweeps the count memory one channel per cycle, then drains up
// to eight expiry beats, one a cycle while the output register is free to take one.
// The single read/write port pair of the count memory sets the sweep length.
// Reset: rst_n clears the enable, pause and periodic flags, the id counter and
// all control state; the count memory needs no clearing pass.
// Stalls: a finished beat waits in the output register while the next item is
// accepted; a new result waits for out_ready before it replaces it.
module multi_channel_software_timer_bank_unit
    import tmb_pkg::*;
#(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          mode,
    input  logic [2:0]          timer_id,
    input  logic [31:0]         ticks,
    input  logic                periodic,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                expiry_event,
    output logic [CHAN_W-1:0]   channel,
    output logic                expired,
    output logic                enabled,
    output logic                paused,
    output logic [ACT_W-1:0]    active_count,
    output logic                accepted,
    output logic                last
);

    // Index width for a channel and counter width that also holds NUM_TIMERS
    localparam int IDW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNTW = $clog2(NUM_TIMERS + 1);

    fsm_status_t status;
    fsm_ctrl_t   ctrl;

    tmb_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    logic in_fire;
    op_t  op;

    assign in_ready = ctrl.in_ready;
    assign in_fire  = in_valid && ctrl.in_ready;
    assign op       = op_t'(mode);

    // Per-channel flags live in flops; period and count live in the memory
    logic [NUM_TIMERS-1:0] enabled_reg, enabled_next;
    logic [NUM_TIMERS-1:0] paused_reg, paused_next;
    logic [NUM_TIMERS-1:0] periodic_reg, periodic_next;
    logic [CNTW-1:0]       ids_alloc_reg, ids_alloc_next;
    logic [CNTW-1:0]       act_cnt_reg, act_cnt_next;

    // Addressed channel, widened so that it can be range checked and truncated
    logic [IDW+2:0]            id_ext;
    logic                      id_ok;
    logic [IDW-1:0]            id_idx;
    logic                      alloc_ok;
    logic [IDW-1:0]            alloc_idx;
    logic [IDW+CHAN_W-1:0]     alloc_ext;
    logic [COUNT_WIDTH+31:0]   ticks_ext;
    logic [COUNT_WIDTH-1:0]    ticks_cw;
    logic                      start_ok;

    assign id_ext    = {{IDW{1'b0}}, timer_id};
    assign id_ok     = id_ext < (IDW+3)'(NUM_TIMERS);
    assign id_idx    = id_ok ? id_ext[IDW-1:0] : '0;
    assign alloc_ok  = ids_alloc_reg < CNTW'(NUM_TIMERS);
    assign alloc_idx = ids_alloc_reg[IDW-1:0];
    assign alloc_ext = {{CHAN_W{1'b0}}, alloc_idx};
    assign ticks_ext = {{COUNT_WIDTH{1'b0}}, ticks};
    assign ticks_cw  = ticks_ext[COUNT_WIDTH-1:0];
    assign start_ok  = id_ok && (ticks_cw != '0);

    // Count memory: {period, count} per channel
    logic                     ram_we;
    logic [IDW-1:0]           ram_waddr;
    logic [2*COUNT_WIDTH-1:0] ram_wdata;
    logic                     ram_re;
    logic [IDW-1:0]           ram_raddr;
    logic [2*COUNT_WIDTH-1:0] ram_rdata;

    tmb_ram #(
        .WIDTH (2 * COUNT_WIDTH),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [COUNT_WIDTH-1:0] rd_period;
    logic [COUNT_WIDTH-1:0] rd_count;

    assign rd_period = ram_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign rd_count  = ram_rdata[COUNT_WIDTH-1:0];

    // Sweep pipeline: read channel i while channel i-1 is decremented
    logic [CNTW-1:0] rd_idx_reg, rd_idx_next;
    logic [IDW-1:0]  proc_idx_reg, proc_idx_next;
    logic            rd_more;
    logic            proc_act;
    logic [COUNT_WIDTH-1:0] proc_dec;
    logic            proc_hit;
    logic [COUNT_WIDTH-1:0] proc_new;
    logic [IDW+CHAN_W-1:0]  proc_ext;

    assign rd_more  = rd_idx_reg < CNTW'(NUM_TIMERS);
    assign proc_act = enabled_reg[proc_idx_reg] && !paused_reg[proc_idx_reg];
    assign proc_dec = rd_count - COUNT_WIDTH'(1);
    assign proc_hit = proc_act && (proc_dec == '0);
    assign proc_new = (proc_hit && periodic_reg[proc_idx_reg]) ? rd_period : proc_dec;
    assign proc_ext = {{CHAN_W{1'b0}}, proc_idx_reg};

    always_comb
    begin
        ram_re        = 1'b0;
        ram_raddr     = id_idx;
        rd_idx_next   = rd_idx_reg;
        proc_idx_next = proc_idx_reg;
        if (in_fire && (op == OP_TICK))
        begin
            // Start the sweep at channel 0
            ram_re        = 1'b1;
            ram_raddr     = '0;
            rd_idx_next   = CNTW'(1);
            proc_idx_next = '0;
        end
        else if (in_fire && (op == OP_QUERY))
        begin
            ram_re    = 1'b1;
            ram_raddr = id_idx;
        end
        else if (ctrl.sweep_run && rd_more)
        begin
            ram_re        = 1'b1;
            ram_raddr     = rd_idx_reg[IDW-1:0];
            rd_idx_next   = rd_idx_reg + CNTW'(1);
            proc_idx_next = rd_idx_reg[IDW-1:0];
        end
    end

    always_comb
    begin
        if (ctrl.sweep_run)
        begin
            ram_we    = proc_act;
            ram_waddr = proc_idx_reg;
            ram_wdata = {rd_period, proc_new};
        end
        else
        begin
            ram_we    = in_fire && (op == OP_START) && start_ok;
            ram_waddr = id_idx;
            ram_wdata = {ticks_cw, ticks_cw};
        end
    end

    // Flag and counter updates; at most one channel changes per cycle
    always_comb
    begin
        enabled_next   = enabled_reg;
        paused_next    = paused_reg;
        periodic_next  = periodic_reg;
        ids_alloc_next = ids_alloc_reg;
        act_cnt_next   = act_cnt_reg;
        if (in_fire)
        begin
            case (op)
                OP_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        if (enabled_reg[alloc_idx])
                        begin
                            act_cnt_next = act_cnt_reg - CNTW'(1);
                        end
                        enabled_next[alloc_idx] = 1'b0;
                        ids_alloc_next = ids_alloc_reg + CNTW'(1);
                    end
                end
                OP_START:
                begin
                    if (start_ok)
                    begin
                        if (!enabled_reg[id_idx])
                        begin
                            act_cnt_next = act_cnt_reg + CNTW'(1);
                        end
                        enabled_next[id_idx]  = 1'b1;
                        paused_next[id_idx]   = 1'b0;
                        periodic_next[id_idx] = periodic;
                    end
                end
                OP_STOP:
                begin
                    if (id_ok && enabled_reg[id_idx])
                    begin
                        act_cnt_next = act_cnt_reg - CNTW'(1);
                        enabled_next[id_idx] = 1'b0;
                    end
                end
                OP_TOGGLE:
                begin
                    if (id_ok && enabled_reg[id_idx])
                    begin
                        paused_next[id_idx] = !paused_reg[id_idx];
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (ctrl.sweep_run && proc_hit && !periodic_reg[proc_idx_reg])
        begin
            // One-shot expiry: drop the enable
            enabled_next[proc_idx_reg] = 1'b0;
            act_cnt_next = act_cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= '0;
            paused_reg    <= '0;
            periodic_reg  <= '0;
            ids_alloc_reg <= '0;
            act_cnt_reg   <= '0;
            rd_idx_reg    <= '0;
            proc_idx_reg  <= '0;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            paused_reg    <= paused_next;
            periodic_reg  <= periodic_next;
            ids_alloc_reg <= ids_alloc_next;
            act_cnt_reg   <= act_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            proc_idx_reg  <= proc_idx_next;
        end
    end

    // Expiry buffer: hold up to eight channel numbers until the sweep ends,
    // since every beat carries the count of enabled channels after the tick
    logic [CHAN_W-1:0]    xbuf_reg [MAX_RESULTS];
    logic [RES_CNT_W-1:0] fill_reg, fill_next;
    logic [RES_IDX_W-1:0] emit_ptr_reg, emit_ptr_next;
    logic                 xbuf_push;
    logic                 emit_last;

    assign xbuf_push = ctrl.sweep_run && proc_hit && (fill_reg < RES_CNT_W'(MAX_RESULTS));
    assign emit_last = ({1'b0, emit_ptr_reg} + RES_CNT_W'(1)) == fill_reg;

    always_comb
    begin
        fill_next     = fill_reg;
        emit_ptr_next = emit_ptr_reg;
        if (in_fire && (op == OP_TICK))
        begin
            fill_next     = '0;
            emit_ptr_next = '0;
        end
        else
        begin
            if (xbuf_push)
            begin
                fill_next = fill_reg + RES_CNT_W'(1);
            end
            if (ctrl.emit_load)
            begin
                emit_ptr_next = emit_ptr_reg + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            emit_ptr_reg <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            emit_ptr_reg <= emit_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xbuf_push)
        begin
            xbuf_reg[fill_reg[RES_IDX_W-1:0]] <= proc_ext[CHAN_W-1:0];
        end
    end

    // Single-result operations: capture the answer at accept
    logic              resp_query_reg;
    logic [CHAN_W-1:0] resp_chan_reg;
    logic              resp_en_reg;
    logic              resp_pa_reg;
    logic              resp_acc_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            resp_query_reg <= (op == OP_QUERY);
            resp_en_reg    <= (op == OP_QUERY) && id_ok && enabled_reg[id_idx];
            resp_pa_reg    <= (op == OP_QUERY) && id_ok && paused_reg[id_idx];
            case (op)
                OP_ALLOC:
                begin
                    resp_chan_reg <= alloc_ok ? alloc_ext[CHAN_W-1:0] : '0;
                    resp_acc_reg  <= alloc_ok;
                end
                OP_START:
                begin
                    resp_chan_reg <= timer_id;
                    resp_acc_reg  <= start_ok;
                end
                OP_STOP, OP_TOGGLE, OP_QUERY:
                begin
                    resp_chan_reg <= timer_id;
                    resp_acc_reg  <= 1'b0;
                end
                default:
                begin
                    resp_chan_reg <= '0;
                    resp_acc_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Output register
    logic              out_valid_reg;
    logic              expiry_event_reg;
    logic [CHAN_W-1:0] channel_reg;
    logic              expired_reg;
    logic              enabled_out_reg;
    logic              paused_out_reg;
    logic [ACT_W-1:0]  active_count_reg;
    logic              accepted_reg;
    logic              last_reg;
    logic              out_free;
    logic [ACT_W-1:0]  act_sat;

    assign out_free = !out_valid_reg || out_ready;
    assign act_sat  = (act_cnt_reg > CNTW'(ACT_MAX)) ? ACT_W'(ACT_MAX)
                                                      : ACT_W'(act_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.resp_load || ctrl.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.resp_load)
        begin
            expiry_event_reg <= 1'b0;
            channel_reg      <= resp_chan_reg;
            expired_reg      <= resp_query_reg && resp_en_reg && (rd_count == '0);
            enabled_out_reg  <= resp_en_reg;
            paused_out_reg   <= resp_pa_reg;
            active_count_reg <= act_sat;
            accepted_reg     <= resp_acc_reg;
            last_reg         <= 1'b1;
        end
        else if (ctrl.emit_load)
        begin
            expiry_event_reg <= 1'b1;
            channel_reg      <= xbuf_reg[emit_ptr_reg];
            expired_reg      <= 1'b0;
            enabled_out_reg  <= 1'b0;
            paused_out_reg   <= 1'b0;
            active_count_reg <= act_sat;
            accepted_reg     <= 1'b0;
            last_reg         <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign expiry_event = expiry_event_reg;
    assign channel      = channel_reg;
    assign expired      = expired_reg;
    assign enabled      = enabled_out_reg;
    assign paused       = paused_out_reg;
    assign active_count = active_count_reg;
    assign accepted     = accepted_reg;
    assign last         = last_reg;

    // FSM status
    assign status.in_fire    = in_fire;
    assign status.is_tick    = (op == OP_TICK);
    assign status.sweep_done = !rd_more;
    assign status.res_empty  = (fill_reg == '0);
    assign status.out_free   = out_free;
    assign status.emit_last  = emit_last;

    // Running enable count tracks the flags exactly
    a_act_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        act_cnt_reg == CNTW'($countones(enabled_reg)))
        else $error("active count out of step with enable flags");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("expiry buffer overfilled");

    a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= CNTW'(NUM_TIMERS))
        else $error("sweep read index past last channel");

    a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !ctrl.sweep_run) |-> (in_fire && (op == OP_START)))
        else $error("count memory written outside sweep or start");

    a_emit_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit_load && emit_last) |=> !ctrl.emit_load)
        else $error("expiry beat issued after last one");

endmodule
